>>> src/trs_pkg.sv
// shared types and constants for the trs transform compose block
package trs_pkg;

  localparam int VALUE_WIDTH_DEF = 32;
  localparam int QUAT_WIDTH_DEF  = 16;
  localparam int FIFO_DEPTH      = 4;

  typedef logic [1:0] row_idx_t;

  localparam row_idx_t ROW_FIRST     = 2'd0;
  localparam row_idx_t ROW_TRANSLATE = 2'd3;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

>>> src/trs_fifo.sv
// small queue between the front and back parts
module trs_fifo
  import trs_pkg::*;
#(
  parameter int DATA_WIDTH = 8,
  parameter int DEPTH      = FIFO_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  logic [DATA_WIDTH-1:0] wdata,
  input  logic                  pop,
  output logic [DATA_WIDTH-1:0] rdata,
  output fifo_stat_t            stat
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [DATA_WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]         wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]         rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]         count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  assign rdata      = mem_r[rd_ptr_r];
  assign stat.full  = (count_r == CW'(DEPTH));
  assign stat.empty = (count_r == '0);

endmodule

>>> src/trs_front.sv
// front part: takes transfers, forms quaternion products and rotation entries
module trs_front
  import trs_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
  parameter int QUAT_WIDTH  = QUAT_WIDTH_DEF,
  localparam int RW = 2 * QUAT_WIDTH + 3,
  localparam int DW = 9 * RW + 6 * VALUE_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [VALUE_WIDTH-1:0] pos_x,
  input  logic signed [VALUE_WIDTH-1:0] pos_y,
  input  logic signed [VALUE_WIDTH-1:0] pos_z,
  input  logic signed [QUAT_WIDTH-1:0]  quat_x,
  input  logic signed [QUAT_WIDTH-1:0]  quat_y,
  input  logic signed [QUAT_WIDTH-1:0]  quat_z,
  input  logic signed [QUAT_WIDTH-1:0]  quat_w,
  input  logic signed [VALUE_WIDTH-1:0] scale_x,
  input  logic signed [VALUE_WIDTH-1:0] scale_y,
  input  logic signed [VALUE_WIDTH-1:0] scale_z,
  input  fifo_stat_t                    fifo_stat,
  output logic                          fifo_push,
  output logic [DW-1:0]                 fifo_wdata
);

  localparam int PQ = 2 * QUAT_WIDTH;
  localparam int SH = 2 * (QUAT_WIDTH - 2);
  localparam logic signed [RW-1:0] ONE_ROT = RW'(1) << SH;

  logic                          valid_r;
  logic                          adv;
  logic signed [PQ-1:0]          xx_r, yy_r, zz_r, xy_r, xz_r, yz_r, wx_r, wy_r, wz_r;
  logic signed [VALUE_WIDTH-1:0] pos_r [3];
  logic signed [VALUE_WIDTH-1:0] sc_r [3];
  logic signed [RW-1:0]          rot [9];

  // 2*(p +/- q), optionally as 1 - 2*(p + q)
  function automatic logic signed [RW-1:0] rot_entry(
    input logic signed [PQ-1:0] p,
    input logic signed [PQ-1:0] q,
    input logic                 sub,
    input logic                 one_minus
  );
    logic signed [RW-1:0] pe;
    logic signed [RW-1:0] qe;
    logic signed [RW-1:0] s;
    pe = {{(RW - PQ){p[PQ-1]}}, p};
    qe = {{(RW - PQ){q[PQ-1]}}, q};
    s  = sub ? (pe - qe) : (pe + qe);
    s  = s <<< 1;
    return one_minus ? (ONE_ROT - s) : s;
  endfunction

  assign adv      = !valid_r || !fifo_stat.full;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_valid) begin
      xx_r     <= PQ'(quat_x) * PQ'(quat_x);
      yy_r     <= PQ'(quat_y) * PQ'(quat_y);
      zz_r     <= PQ'(quat_z) * PQ'(quat_z);
      xy_r     <= PQ'(quat_x) * PQ'(quat_y);
      xz_r     <= PQ'(quat_x) * PQ'(quat_z);
      yz_r     <= PQ'(quat_y) * PQ'(quat_z);
      wx_r     <= PQ'(quat_w) * PQ'(quat_x);
      wy_r     <= PQ'(quat_w) * PQ'(quat_y);
      wz_r     <= PQ'(quat_w) * PQ'(quat_z);
      pos_r[0] <= pos_x;
      pos_r[1] <= pos_y;
      pos_r[2] <= pos_z;
      sc_r[0]  <= scale_x;
      sc_r[1]  <= scale_y;
      sc_r[2]  <= scale_z;
    end
  end

  always_comb begin
    rot[0] = rot_entry(yy_r, zz_r, 1'b0, 1'b1);
    rot[1] = rot_entry(xy_r, wz_r, 1'b0, 1'b0);
    rot[2] = rot_entry(xz_r, wy_r, 1'b1, 1'b0);
    rot[3] = rot_entry(xy_r, wz_r, 1'b1, 1'b0);
    rot[4] = rot_entry(xx_r, zz_r, 1'b0, 1'b1);
    rot[5] = rot_entry(yz_r, wx_r, 1'b0, 1'b0);
    rot[6] = rot_entry(xz_r, wy_r, 1'b0, 1'b0);
    rot[7] = rot_entry(yz_r, wx_r, 1'b1, 1'b0);
    rot[8] = rot_entry(xx_r, yy_r, 1'b0, 1'b1);
  end

  // queue word: rotation entries, then scales, then positions
  always_comb begin
    for (int i = 0; i < 9; i++) begin
      fifo_wdata[i*RW +: RW] = rot[i];
    end
    for (int k = 0; k < 3; k++) begin
      fifo_wdata[9*RW + k*VALUE_WIDTH +: VALUE_WIDTH]                 = sc_r[k];
      fifo_wdata[9*RW + (3 + k)*VALUE_WIDTH +: VALUE_WIDTH]           = pos_r[k];
    end
  end

  assign fifo_push = valid_r && !fifo_stat.full;

endmodule

>>> src/trs_back.sv
// back part: emits four rows per item through three shared multipliers
module trs_back
  import trs_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
  parameter int QUAT_WIDTH  = QUAT_WIDTH_DEF,
  localparam int RW = 2 * QUAT_WIDTH + 3,
  localparam int DW = 9 * RW + 6 * VALUE_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [DW-1:0]                 fifo_rdata,
  input  fifo_stat_t                    fifo_stat,
  output logic                          fifo_pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output row_idx_t                      out_row,
  output logic signed [VALUE_WIDTH-1:0] out_col0,
  output logic signed [VALUE_WIDTH-1:0] out_col1,
  output logic signed [VALUE_WIDTH-1:0] out_col2,
  output logic signed [VALUE_WIDTH-1:0] out_col3,
  output logic                          out_last
);

  localparam int VW  = VALUE_WIDTH;
  localparam int SH  = 2 * (QUAT_WIDTH - 2);
  localparam int H   = VW / 2;
  localparam int PLW = RW + H + 1;
  localparam int PHW = RW + VW - H;
  localparam int PW  = RW + VW;
  localparam logic signed [RW-1:0] ONE_ROT = RW'(1) << SH;
  localparam logic signed [VW-1:0] ONE_OUT = VW'(1) << H;
  localparam logic signed [VW-1:0] MAX_OUT = {1'b0, {(VW - 1){1'b1}}};
  localparam logic signed [VW-1:0] MIN_OUT = {1'b1, {(VW - 1){1'b0}}};

  logic                  en;
  logic                  issue;
  row_idx_t              row_r, row_nxt;
  logic                  v1_r, v2_r, out_valid_r;
  row_idx_t              row1_r, row2_r, out_row_r;
  logic signed [RW-1:0]  mul_a [3];
  logic signed [VW-1:0]  mul_b [3];
  logic signed [PLW-1:0] plo_nxt [3];
  logic signed [PHW-1:0] phi_nxt [3];
  logic signed [PLW-1:0] plo1_r [3];
  logic signed [PHW-1:0] phi1_r [3];
  logic signed [PW-1:0]  sum_nxt [3];
  logic signed [PW-1:0]  sum2_r [3];
  logic signed [PW-1:0]  shifted [3];
  logic signed [VW-1:0]  sat_nxt [3];
  logic signed [VW-1:0]  col_r [4];

  assign en       = !out_valid_r || out_ready;
  assign issue    = en && !fifo_stat.empty;
  assign fifo_pop = issue && (row_r == ROW_TRANSLATE);

  always_comb begin
    row_nxt = row_r;
    if (issue) begin
      row_nxt = (row_r == ROW_TRANSLATE) ? ROW_FIRST : row_r + 2'd1;
    end
  end

  // translation row goes through the multipliers as pos * 1.0
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (row_r == ROW_TRANSLATE) begin
        mul_a[c] = ONE_ROT;
        mul_b[c] = fifo_rdata[9*RW + (3 + c)*VW +: VW];
      end else begin
        mul_a[c] = fifo_rdata[(int'(row_r) * 3 + c)*RW +: RW];
        mul_b[c] = fifo_rdata[9*RW + int'(row_r)*VW +: VW];
      end
      plo_nxt[c] = PLW'(mul_a[c]) * PLW'($signed({1'b0, mul_b[c][H-1:0]}));
      phi_nxt[c] = PHW'(mul_a[c]) * PHW'($signed(mul_b[c][VW-1:H]));
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sum_nxt[c] = ({{(PW - PHW){phi1_r[c][PHW-1]}}, phi1_r[c]} <<< H)
                 + {{(PW - PLW){plo1_r[c][PLW-1]}}, plo1_r[c]};
    end
  end

  // floor shift, then clamp to the output range
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      shifted[c] = sum2_r[c] >>> SH;
      if ((&shifted[c][PW-1:VW-1]) || !(|shifted[c][PW-1:VW-1])) begin
        sat_nxt[c] = shifted[c][VW-1:0];
      end else begin
        sat_nxt[c] = shifted[c][PW-1] ? MIN_OUT : MAX_OUT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r       <= ROW_FIRST;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      row_r <= row_nxt;
      if (en) begin
        v1_r        <= issue;
        v2_r        <= v1_r;
        out_valid_r <= v2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      row1_r    <= row_r;
      row2_r    <= row1_r;
      out_row_r <= row2_r;
      for (int c = 0; c < 3; c++) begin
        plo1_r[c] <= plo_nxt[c];
        phi1_r[c] <= phi_nxt[c];
        sum2_r[c] <= sum_nxt[c];
        col_r[c]  <= sat_nxt[c];
      end
      col_r[3] <= (row2_r == ROW_TRANSLATE) ? ONE_OUT : '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_row   = out_row_r;
  assign out_col0  = col_r[0];
  assign out_col1  = col_r[1];
  assign out_col2  = col_r[2];
  assign out_col3  = col_r[3];
  assign out_last  = (out_row_r == ROW_TRANSLATE);

`ifndef ASSERT_OFF
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_pop |-> !fifo_stat.empty)
    else $error("queue popped while empty");

  a_row_step: assert property (@(posedge clk) disable iff (!rst_n)
    (issue && row_r != ROW_TRANSLATE) |=> (row_r == $past(row_r) + 2'd1))
    else $error("row counter skipped a row");

  a_row_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_pop |=> (row_r == ROW_FIRST))
    else $error("row counter did not wrap after the last row");

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && en) |=> out_valid_r)
    else $error("row lost between pipeline and output register");
`endif

endmodule

>>> src/trs_transform_compose_core.sv
// top level of the trs transform compose block
// path: the first row passes the front registers, the queue, then the back part's product,
//   sum and output registers; rows follow one per cycle while out_tready is high
// the back part pops an item only after its last row; three multipliers serve all four rows
// reset: synchronous, active low; clears handshake, queue and row counter state only,
//   the datapath registers are not reset and no clearing pass is needed
module trs_transform_compose_core
  import trs_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
  parameter int QUAT_WIDTH  = QUAT_WIDTH_DEF,
  localparam int IN_TDATA_W  = ((6 * VALUE_WIDTH + 4 * QUAT_WIDTH + 7) / 8) * 8,
  localparam int OUT_TDATA_W = ((4 * VALUE_WIDTH + 7) / 8) * 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // input channel, one transform per transfer
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // pos_x, pos_y, pos_z, quat_x, quat_y, quat_z, quat_w, scale_x, scale_y, scale_z
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // result channel, one matrix row per transfer
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // col0, col1, col2, col3
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // row_index
  output logic [1:0]             out_tuser,
  // last_row
  output logic                   out_tlast
);

  localparam int VW = VALUE_WIDTH;
  localparam int QW = QUAT_WIDTH;
  localparam int RW = 2 * QW + 3;
  localparam int DW = 9 * RW + 6 * VW;
  localparam int QOFS = 3 * VW;           // first quaternion field
  localparam int SOFS = 3 * VW + 4 * QW;  // first scale field

  // unpacked input fields
  logic signed [VW-1:0] pos_x, pos_y, pos_z;
  logic signed [QW-1:0] quat_x, quat_y, quat_z, quat_w;
  logic signed [VW-1:0] scale_x, scale_y, scale_z;

  // queue between the two parts
  fifo_stat_t    fifo_stat;
  logic          fifo_push, fifo_pop;
  logic [DW-1:0] fifo_wdata, fifo_rdata;

  // back part outputs
  row_idx_t             row_idx;
  logic signed [VW-1:0] col0, col1, col2, col3;

  assign pos_x   = in_tdata[0 +: VW];
  assign pos_y   = in_tdata[VW +: VW];
  assign pos_z   = in_tdata[2*VW +: VW];
  assign quat_x  = in_tdata[QOFS +: QW];
  assign quat_y  = in_tdata[QOFS + QW +: QW];
  assign quat_z  = in_tdata[QOFS + 2*QW +: QW];
  assign quat_w  = in_tdata[QOFS + 3*QW +: QW];
  assign scale_x = in_tdata[SOFS +: VW];
  assign scale_y = in_tdata[SOFS + VW +: VW];
  assign scale_z = in_tdata[SOFS + 2*VW +: VW];

  // front: products of the quaternion, rotation entries, into the queue
  trs_front #(
    .VALUE_WIDTH (VW),
    .QUAT_WIDTH  (QW)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .pos_z      (pos_z),
    .quat_x     (quat_x),
    .quat_y     (quat_y),
    .quat_z     (quat_z),
    .quat_w     (quat_w),
    .scale_x    (scale_x),
    .scale_y    (scale_y),
    .scale_z    (scale_z),
    .fifo_stat  (fifo_stat),
    .fifo_push  (fifo_push),
    .fifo_wdata (fifo_wdata)
  );

  // short queue lets the front keep taking transfers while rows drain
  trs_fifo #(
    .DATA_WIDTH (DW),
    .DEPTH      (FIFO_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (fifo_push),
    .wdata (fifo_wdata),
    .pop   (fifo_pop),
    .rdata (fifo_rdata),
    .stat  (fifo_stat)
  );

  // back: scale multiply, floor shift, saturation, output register
  trs_back #(
    .VALUE_WIDTH (VW),
    .QUAT_WIDTH  (QW)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .fifo_rdata (fifo_rdata),
    .fifo_stat  (fifo_stat),
    .fifo_pop   (fifo_pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_row    (row_idx),
    .out_col0   (col0),
    .out_col1   (col1),
    .out_col2   (col2),
    .out_col3   (col3),
    .out_last   (out_tlast)
  );

  // pack the row, zero fill up to whole bytes
  always_comb begin
    out_tdata            = '0;
    out_tdata[4*VW-1:0]  = {col3, col2, col1, col0};
  end

  assign out_tuser = row_idx;

endmodule
